>>> rtl/core/lsf_pkg.sv
package lsf_pkg;

    localparam int unsigned MAX_POINTS_DEF = 1024;
    localparam int unsigned FRAC_BITS_DEF  = 16;

    localparam int unsigned X_W    = 16;
    localparam int unsigned Y_W    = 32;
    localparam int unsigned VAL_W  = 48;
    localparam int unsigned STAT_W = 3;
    localparam int unsigned SX_W   = 26;
    localparam int unsigned SY_W   = 42;
    localparam int unsigned SXY_W  = 58;
    localparam int unsigned SXX_W  = 42;
    localparam int unsigned OP_W   = 64;
    localparam int unsigned PROD_W = 128;

    typedef enum logic [STAT_W-1:0] {
        STAT_FIT_OK      = 3'd0,
        STAT_FIT_DEGEN   = 3'd1,
        STAT_FIT_DROPPED = 3'd2,
        STAT_PRED_OK     = 3'd3,
        STAT_PRED_NOFIT  = 3'd4
    } status_t;

endpackage

>>> rtl/core/least_squares_line_fit_unit.sv
// Least-squares line fit. Add transfers (tuser = 0) accumulate (x, y) into a
// running count and sums of x, y, xy and xx; up to MAX_POINTS samples are
// kept, later ones are dropped and flagged. An add transfer with tlast set also
// fits the line: six products on a shared shift-add multiplier (one multiplier
// bit per cycle) and two restoring divisions, after which one result is offered
// with slope and intercept in signed fixed point with FRAC_BITS fraction bits,
// saturated to 48 bits. A predict transfer (tuser = 1) returns slope*x +
// intercept. The input is not ready while an item is in work; a finished result
// waits in an output register.
module least_squares_line_fit_unit #(
    parameter int unsigned MAX_POINTS = lsf_pkg::MAX_POINTS_DEF,
    parameter int unsigned FRAC_BITS  = lsf_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // x_value[15:0], y_value[47:16]
    input  logic         s_tuser,   // kind
    input  logic         s_tlast,   // last_sample
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata    // slope, intercept, prediction, status, zero pad
);

    localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
    localparam int unsigned VW    = lsf_pkg::VAL_W;
    localparam int unsigned OW    = lsf_pkg::OP_W;
    localparam int unsigned PW    = lsf_pkg::PROD_W;
    localparam logic signed [PW-1:0] POS_LIM = PW'((64'sd1 <<< (VW - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] NEG_LIM = -POS_LIM - PW'(1);

    typedef enum logic [2:0] {S_IDLE, S_ACC, S_MSTART, S_MWAIT, S_DWAIT, S_OUT} state_t;
    typedef enum logic [2:0] {
        ST_DEN_A, ST_DEN_B, ST_SLP_A, ST_SLP_B, ST_ICP_A, ST_ICP_B, ST_PRED
    } step_t;

    state_t state_reg;
    step_t  step_reg;

    logic                        kind_reg;
    logic                        last_reg;
    logic [lsf_pkg::X_W-1:0]     x_reg;
    logic signed [lsf_pkg::Y_W-1:0] y_reg;
    logic signed [48:0]          xy_reg;
    logic [31:0]                 xx_reg;

    logic [CNT_W-1:0]            count_reg;
    logic [lsf_pkg::SX_W-1:0]    sum_x_reg;
    logic signed [lsf_pkg::SY_W-1:0]  sum_y_reg;
    logic signed [lsf_pkg::SXY_W-1:0] sum_xy_reg;
    logic [lsf_pkg::SXX_W-1:0]   sum_xx_reg;
    logic                        dropped_reg;
    logic [VW-1:0]               stored_slope_reg;
    logic [VW-1:0]               stored_icpt_reg;
    logic                        fit_valid_reg;

    logic [PW-1:0]               t_reg;
    logic [OW-1:0]               den_reg;
    logic [VW-1:0]               slope_reg;

    logic                        m_valid_reg;
    logic [VW-1:0]               out_slope_reg;
    logic [VW-1:0]               out_icpt_reg;
    logic [VW-1:0]               out_pred_reg;
    lsf_pkg::status_t            out_status_reg;

    logic                        mul_start;
    logic signed [OW-1:0]        mul_a;
    logic [OW-1:0]               mul_b;
    logic                        mul_done;
    logic [PW-1:0]               mul_prod;
    logic                        div_start;
    logic [PW-1:0]               div_num;
    logic                        div_done;
    logic signed [VW-1:0]        div_quot;

    logic [PW-1:0]               diff;
    logic signed [PW-1:0]        pred_full;
    logic [VW-1:0]               pred_sat;
    logic [OW-1:0]               n_op;

    assign n_op = OW'(count_reg);

    always_comb
    begin
        case (step_reg)
            ST_DEN_A:
            begin
                mul_a = OW'(sum_xx_reg);
                mul_b = n_op;
            end
            ST_DEN_B:
            begin
                mul_a = OW'(sum_x_reg);
                mul_b = OW'(sum_x_reg);
            end
            ST_SLP_A:
            begin
                mul_a = {{(OW-lsf_pkg::SXY_W){sum_xy_reg[lsf_pkg::SXY_W-1]}}, sum_xy_reg};
                mul_b = n_op;
            end
            ST_SLP_B:
            begin
                mul_a = {{(OW-lsf_pkg::SY_W){sum_y_reg[lsf_pkg::SY_W-1]}}, sum_y_reg};
                mul_b = OW'(sum_x_reg);
            end
            ST_ICP_A:
            begin
                mul_a = {{(OW-lsf_pkg::SY_W){sum_y_reg[lsf_pkg::SY_W-1]}}, sum_y_reg};
                mul_b = OW'(sum_xx_reg);
            end
            ST_ICP_B:
            begin
                mul_a = {{(OW-lsf_pkg::SXY_W){sum_xy_reg[lsf_pkg::SXY_W-1]}}, sum_xy_reg};
                mul_b = OW'(sum_x_reg);
            end
            default:
            begin
                mul_a = {{(OW-VW){stored_slope_reg[VW-1]}}, stored_slope_reg};
                mul_b = OW'(x_reg);
            end
        endcase
        diff      = t_reg - mul_prod;
        div_num   = diff;
        pred_full = $signed(mul_prod) + $signed({{(PW-VW){stored_icpt_reg[VW-1]}},
                                                 stored_icpt_reg});
        if (pred_full > POS_LIM)
        begin
            pred_sat = POS_LIM[VW-1:0];
        end
        else if (pred_full < NEG_LIM)
        begin
            pred_sat = NEG_LIM[VW-1:0];
        end
        else
        begin
            pred_sat = pred_full[VW-1:0];
        end
    end

    assign mul_start = (state_reg == S_MSTART);
    assign div_start = (state_reg == S_MWAIT) && mul_done
                       && ((step_reg == ST_SLP_B) || (step_reg == ST_ICP_B));

    lsf_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    lsf_serial_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            step_reg         <= ST_DEN_A;
            count_reg        <= '0;
            sum_x_reg        <= '0;
            sum_y_reg        <= '0;
            sum_xy_reg       <= '0;
            sum_xx_reg       <= '0;
            dropped_reg      <= 1'b0;
            stored_slope_reg <= '0;
            stored_icpt_reg  <= '0;
            fit_valid_reg    <= 1'b0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_OUT) && (!m_valid_reg || m_tready))
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if (s_tuser)
                        begin
                            step_reg  <= ST_PRED;
                            state_reg <= S_MSTART;
                        end
                        else
                        begin
                            state_reg <= S_ACC;
                        end
                    end
                end
                S_ACC:
                begin
                    if (count_reg < CNT_W'(MAX_POINTS))
                    begin
                        count_reg  <= count_reg + CNT_W'(1);
                        sum_x_reg  <= sum_x_reg + lsf_pkg::SX_W'(x_reg);
                        sum_y_reg  <= sum_y_reg
                                      + {{(lsf_pkg::SY_W-lsf_pkg::Y_W){y_reg[lsf_pkg::Y_W-1]}},
                                         y_reg};
                        sum_xy_reg <= sum_xy_reg
                                      + {{(lsf_pkg::SXY_W-49){xy_reg[48]}}, xy_reg};
                        sum_xx_reg <= sum_xx_reg + lsf_pkg::SXX_W'(xx_reg);
                    end
                    else
                    begin
                        dropped_reg <= 1'b1;
                    end
                    if (last_reg)
                    begin
                        step_reg  <= ST_DEN_A;
                        state_reg <= S_MSTART;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_MSTART:
                begin
                    state_reg <= S_MWAIT;
                end
                S_MWAIT:
                begin
                    if (mul_done)
                    begin
                        unique case (step_reg)
                            ST_DEN_A, ST_SLP_A, ST_ICP_A:
                            begin
                                step_reg  <= step_t'(step_reg + 3'd1);
                                state_reg <= S_MSTART;
                            end
                            ST_DEN_B:
                            begin
                                if (diff[OW-1:0] == '0)
                                begin
                                    stored_slope_reg <= '0;
                                    stored_icpt_reg  <= '0;
                                    fit_valid_reg    <= 1'b0;
                                    state_reg        <= S_OUT;
                                end
                                else
                                begin
                                    step_reg  <= ST_SLP_A;
                                    state_reg <= S_MSTART;
                                end
                            end
                            ST_SLP_B, ST_ICP_B:
                            begin
                                state_reg <= S_DWAIT;
                            end
                            default:
                            begin
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_DWAIT:
                begin
                    if (div_done)
                    begin
                        if (step_reg == ST_SLP_B)
                        begin
                            step_reg  <= ST_ICP_A;
                            state_reg <= S_MSTART;
                        end
                        else
                        begin
                            stored_slope_reg <= slope_reg;
                            stored_icpt_reg  <= div_quot;
                            fit_valid_reg    <= 1'b1;
                            state_reg        <= S_OUT;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        state_reg   <= S_IDLE;
                        if (step_reg != ST_PRED)
                        begin
                            count_reg   <= '0;
                            sum_x_reg   <= '0;
                            sum_y_reg   <= '0;
                            sum_xy_reg  <= '0;
                            sum_xx_reg  <= '0;
                            dropped_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && s_tvalid)
        begin
            kind_reg <= s_tuser;
            last_reg <= s_tlast;
            x_reg    <= s_tdata[15:0];
            y_reg    <= $signed(s_tdata[47:16]);
            xy_reg   <= $signed({17'b0, s_tdata[15:0]}) * $signed(s_tdata[47:16]);
            xx_reg   <= 32'(s_tdata[15:0]) * 32'(s_tdata[15:0]);
        end
        if ((state_reg == S_MWAIT) && mul_done)
        begin
            t_reg <= mul_prod;
            if (step_reg == ST_DEN_B)
            begin
                den_reg <= diff[OW-1:0];
            end
        end
        if ((state_reg == S_DWAIT) && div_done && (step_reg == ST_SLP_B))
        begin
            slope_reg <= div_quot;
        end
        // the multiplier holds its product until the next start
        if ((state_reg == S_OUT) && (!m_valid_reg || m_tready))
        begin
            if (kind_reg)
            begin
                out_slope_reg  <= stored_slope_reg;
                out_icpt_reg   <= stored_icpt_reg;
                out_pred_reg   <= pred_sat;
                out_status_reg <= fit_valid_reg ? lsf_pkg::STAT_PRED_OK
                                                : lsf_pkg::STAT_PRED_NOFIT;
            end
            else
            begin
                out_slope_reg  <= stored_slope_reg;
                out_icpt_reg   <= stored_icpt_reg;
                out_pred_reg   <= '0;
                if (!fit_valid_reg)
                begin
                    out_status_reg <= lsf_pkg::STAT_FIT_DEGEN;
                end
                else
                begin
                    out_status_reg <= dropped_reg ? lsf_pkg::STAT_FIT_DROPPED
                                                  : lsf_pkg::STAT_FIT_OK;
                end
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, out_status_reg, out_pred_reg, out_icpt_reg, out_slope_reg};

endmodule

>>> rtl/core/lsf_serial_mul.sv
module lsf_serial_mul (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [lsf_pkg::OP_W-1:0]  a,
    input  logic        [lsf_pkg::OP_W-1:0]  b,
    output logic                             done,
    output logic        [lsf_pkg::PROD_W-1:0] prod
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [lsf_pkg::PROD_W-1:0]   acc_reg;
    logic [lsf_pkg::PROD_W-1:0]   mcand_reg;
    logic [lsf_pkg::OP_W-1:0]     mplier_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (mplier_reg == '0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // shift-add, one multiplier bit per cycle; stop once the remaining bits are zero
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= {{(lsf_pkg::PROD_W-lsf_pkg::OP_W){a[lsf_pkg::OP_W-1]}}, a};
            mplier_reg <= b;
        end
        else if (busy_reg && (mplier_reg != '0))
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[lsf_pkg::PROD_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[lsf_pkg::OP_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

>>> rtl/core/lsf_serial_div.sv
module lsf_serial_div #(
    parameter int unsigned FRAC_BITS = lsf_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [lsf_pkg::PROD_W-1:0]        num,
    input  logic [lsf_pkg::OP_W-1:0]          den,
    output logic                              done,
    output logic signed [lsf_pkg::VAL_W-1:0]  quot
);

    localparam int unsigned PW    = lsf_pkg::PROD_W;
    localparam int unsigned CNT_W = $clog2(PW);
    localparam logic [PW-1:0] POS_LIM = PW'((64'd1 << (lsf_pkg::VAL_W - 1)) - 64'd1);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} state_t;

    state_t                   state_reg;
    logic                     done_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     neg_reg;
    logic [PW-1:0]            m_reg;
    logic [PW-1:0]            q_reg;
    logic [lsf_pkg::OP_W:0]   rem_reg;
    logic [lsf_pkg::OP_W-1:0] den_reg;
    logic [lsf_pkg::VAL_W-1:0] quot_reg;

    logic [PW-1:0]            mag;
    logic [lsf_pkg::OP_W:0]   r2;
    logic                     ge;
    logic [lsf_pkg::OP_W:0]   half_gap;
    logic [PW-1:0]            q_rnd;
    logic [lsf_pkg::VAL_W-1:0] sat_val;

    always_comb
    begin
        mag      = num[PW-1] ? (~num + PW'(1)) : num;
        r2       = {rem_reg[lsf_pkg::OP_W-1:0], m_reg[PW-1]};
        ge       = (r2 >= {1'b0, den_reg});
        half_gap = {1'b0, den_reg} - rem_reg;
        q_rnd    = (rem_reg >= half_gap) ? (q_reg + PW'(1)) : q_reg;
        if (neg_reg)
        begin
            if (q_rnd > POS_LIM)
            begin
                sat_val = {1'b1, {(lsf_pkg::VAL_W-1){1'b0}}};
            end
            else
            begin
                sat_val = ~q_rnd[lsf_pkg::VAL_W-1:0] + lsf_pkg::VAL_W'(1);
            end
        end
        else
        begin
            sat_val = (q_rnd > POS_LIM) ? POS_LIM[lsf_pkg::VAL_W-1:0]
                                        : q_rnd[lsf_pkg::VAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_RUN;
                        cnt_reg   <= '0;
                    end
                end
                S_RUN:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(PW - 1))
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // restoring division, one quotient bit per cycle, then round and saturate
    always_ff @(posedge clk)
    begin
        if (start && (state_reg == S_IDLE))
        begin
            neg_reg <= num[PW-1];
            m_reg   <= mag << FRAC_BITS;
            q_reg   <= '0;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (state_reg == S_RUN)
        begin
            m_reg   <= {m_reg[PW-2:0], 1'b0};
            q_reg   <= {q_reg[PW-2:0], ge};
            rem_reg <= ge ? (r2 - {1'b0, den_reg}) : r2;
        end
        else if (state_reg == S_FIN)
        begin
            quot_reg <= sat_val;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
